FILE: hw/rtl/cc20_pkg.sv
// Shared types and constants for the ChaCha20 stream XOR block.
`default_nettype none
package cc20_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int NUM_CELLS = 4;
	localparam int WORDS_PER_BLOCK = 8;

	localparam logic [31:0] SIGMA [NUM_CELLS] = '{
		32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
	};

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_KEY_LOW       = 3'd0,
		CFG_KEY_MID_LOW   = 3'd1,
		CFG_KEY_MID_HIGH  = 3'd2,
		CFG_KEY_HIGH      = 3'd3,
		CFG_NONCE         = 3'd4,
		CFG_START_COUNTER = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [63:0] data_in;
		logic [3:0]  valid_bytes;
		logic        last_of_message;
	} in_item_t;

	typedef struct packed {
		logic [63:0] data_out;
		logic [3:0]  valid_bytes_out;
		logic        last_out;
	} out_item_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} col_t;

	typedef struct packed {
		logic load;
		logic round;
		logic add;
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cc20_cell.sv
// One column cell of the ChaCha20 state ring: four state words and a quarter round.
`default_nettype none
module cc20_cell (
	input  logic                clk,
	input  cc20_pkg::cell_ctrl_t ctrl,
	input  cc20_pkg::col_t      init,
	input  logic [31:0]         b_in,
	input  logic [31:0]         c_in,
	input  logic [31:0]         d_in,
	output cc20_pkg::col_t      qr,
	output cc20_pkg::col_t      col
);
	import cc20_pkg::*;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	col_t col_q;
	logic [31:0] a1, b1, c1, d1;
	logic [31:0] a2, b2, c2, d2;

	always_comb begin
		a1 = col_q.a + col_q.b;
		d1 = rotl32(col_q.d ^ a1, 16);
		c1 = col_q.c + d1;
		b1 = rotl32(col_q.b ^ c1, 12);
		a2 = a1 + b1;
		d2 = rotl32(d1 ^ a2, 8);
		c2 = c1 + d2;
		b2 = rotl32(b1 ^ c2, 7);
	end

	assign qr = '{a: a2, b: b2, c: c2, d: d2};
	assign col = col_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			col_q <= init;
		end else if (ctrl.round) begin
			col_q <= '{a: a2, b: b_in, c: c_in, d: d_in};
		end else if (ctrl.add) begin
			col_q <= '{a: col_q.a + init.a, b: col_q.b + init.b,
				c: col_q.c + init.c, d: col_q.d + init.d};
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/chacha20_stream_xor.sv
// Top level of the ChaCha20 stream XOR block: control, configuration and the cell ring.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_ready   in_item (data, byte count, last flag)
//   out       output     out_valid / out_ready out_item (data, byte count, last flag)
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// An item at word position 0 runs ROUND_COUNT rounded up to even rounds: the accepting
// cycle loads the cells, then one round per cycle in the ring of four column cells, then
// the add-back step, and the result is registered once the output register is free.
// Items at other positions are XORed with the held keystream and registered directly.
// Reset clears the counter, the position and the control state; the key and nonce
// registers reset to zero. A full output register stalls ST_EMIT and positions 1 to 7.
`default_nettype none
module chacha20_stream_xor #(
	parameter int ROUND_COUNT = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  cc20_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output cc20_pkg::out_item_t               out_item,
	input  logic                              cfg_we,
	input  logic [cc20_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [cc20_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cc20_pkg::*;

	localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
	localparam int ROUNDS_TOTAL = 2 * DOUBLE_ROUNDS;
	localparam int RCNT_W = $clog2(ROUNDS_TOTAL);
	localparam logic [RCNT_W-1:0] RCNT_LAST = RCNT_W'(ROUNDS_TOTAL - 1);

	state_t state_q, state_nxt;
	logic [RCNT_W-1:0] rcnt_q;
	logic [63:0] key_q [4];
	logic [63:0] nonce_q;
	logic [63:0] counter_q;
	logic [2:0] pos_q;
	in_item_t item_q;
	logic out_valid_q;
	out_item_t out_item_q;

	cell_ctrl_t cell_ctrl;
	logic in_fire;
	logic out_free;
	logic out_load;
	logic capture;
	in_item_t src_item;
	logic [63:0] ks_word;
	logic [63:0] byte_mask;

	logic [31:0] init_w [16];
	logic [31:0] st_w [16];
	logic [63:0] ks_w [WORDS_PER_BLOCK];
	col_t cell_init [NUM_CELLS];
	col_t cell_qr [NUM_CELLS];
	col_t cell_col [NUM_CELLS];
	logic [31:0] b_in [NUM_CELLS];
	logic [31:0] c_in [NUM_CELLS];
	logic [31:0] d_in [NUM_CELLS];

	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Initial state words: constants, key, counter and nonce.
	always_comb begin
		for (int i = 0; i < NUM_CELLS; i++) begin
			init_w[i] = SIGMA[i];
			init_w[4 + 2 * i] = key_q[i][31:0];
			init_w[5 + 2 * i] = key_q[i][63:32];
		end
		init_w[12] = counter_q[31:0];
		init_w[13] = counter_q[63:32];
		init_w[14] = nonce_q[31:0];
		init_w[15] = nonce_q[63:32];
	end

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		localparam int NB1 = (i + 1) % NUM_CELLS;
		localparam int NB2 = (i + 2) % NUM_CELLS;
		localparam int NB3 = (i + 3) % NUM_CELLS;

		assign cell_init[i] = '{a: init_w[i], b: init_w[4 + i], c: init_w[8 + i],
			d: init_w[12 + i]};

		// After a column round the rows turn into diagonals; after a diagonal round back.
		assign b_in[i] = rcnt_q[0] ? cell_qr[NB3].b : cell_qr[NB1].b;
		assign c_in[i] = cell_qr[NB2].c;
		assign d_in[i] = rcnt_q[0] ? cell_qr[NB1].d : cell_qr[NB3].d;

		cc20_cell u_cell (
			.clk  (clk),
			.ctrl (cell_ctrl),
			.init (cell_init[i]),
			.b_in (b_in[i]),
			.c_in (c_in[i]),
			.d_in (d_in[i]),
			.qr   (cell_qr[i]),
			.col  (cell_col[i])
		);

		assign st_w[i] = cell_col[i].a;
		assign st_w[4 + i] = cell_col[i].b;
		assign st_w[8 + i] = cell_col[i].c;
		assign st_w[12 + i] = cell_col[i].d;
	end

	always_comb begin
		for (int p = 0; p < WORDS_PER_BLOCK; p++) begin
			ks_w[p] = {st_w[2 * p + 1], st_w[2 * p]};
		end
	end

	assign ks_word = ks_w[pos_q];
	assign src_item = (state_q == ST_IDLE) ? in_item : item_q;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			byte_mask[8 * k +: 8] = (src_item.valid_bytes > 4'(k)) ? 8'hff : 8'h00;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && pos_q == 3'd0) begin
					state_nxt = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rcnt_q == RCNT_LAST) begin
					state_nxt = ST_ADD;
				end
			end
			ST_ADD: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		in_ready = 1'b0;
		cell_ctrl = '0;
		out_load = 1'b0;
		capture = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = (pos_q == 3'd0) || out_free;
				if (in_fire) begin
					if (pos_q == 3'd0) begin
						cell_ctrl.load = 1'b1;
						capture = 1'b1;
					end else begin
						out_load = 1'b1;
					end
				end
			end
			ST_ROUND: begin
				cell_ctrl.round = 1'b1;
			end
			ST_ADD: begin
				cell_ctrl.add = 1'b1;
			end
			ST_EMIT: begin
				out_load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rcnt_q <= '0;
			out_valid_q <= 1'b0;
			counter_q <= '0;
			pos_q <= '0;
			nonce_q <= '0;
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (cell_ctrl.load) begin
				rcnt_q <= '0;
			end else if (cell_ctrl.round) begin
				rcnt_q <= rcnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_KEY_LOW, CFG_KEY_MID_LOW, CFG_KEY_MID_HIGH, CFG_KEY_HIGH: begin
						key_q[cfg_index[1:0]] <= cfg_data;
						counter_q <= '0;
						pos_q <= '0;
					end
					CFG_NONCE: begin
						nonce_q <= cfg_data;
						counter_q <= '0;
						pos_q <= '0;
					end
					CFG_START_COUNTER: begin
						counter_q <= cfg_data;
						pos_q <= '0;
					end
					default: begin
						pos_q <= pos_q;
					end
				endcase
			end else if (out_load) begin
				if (pos_q == 3'd7 || src_item.last_of_message) begin
					counter_q <= counter_q + 64'd1;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			item_q <= in_item;
		end
		if (out_load) begin
			out_item_q.data_out <= (src_item.data_in ^ ks_word) & byte_mask;
			out_item_q.valid_bytes_out <= src_item.valid_bytes;
			out_item_q.last_out <= src_item.last_of_message;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule
`default_nettype wire

FILE: dv/chacha20_xor_checker.sv
// Checker for the ChaCha20 stream XOR block: predicts every output item and compares it.
`timescale 1ns / 1ps
module chacha20_xor_checker #(
	parameter int ROUND_COUNT = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  cc20_pkg::in_item_t                in_item,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  cc20_pkg::out_item_t               out_item,
	input  logic                              cfg_we,
	input  logic [cc20_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [cc20_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                fail_count,
	output int                                pending
);
	import cc20_pkg::*;

	logic [63:0] key_words [4];
	logic [63:0] nonce;
	logic [63:0] block_ctr;
	logic [2:0]  word_pos;
	logic [63:0] keystream [WORDS_PER_BLOCK];
	logic [31:0] mix [16];
	out_item_t   expected_words [$];
	int          mismatches = 0;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void quarter_round(input int a, input int b, input int c, input int d);
		mix[a] = mix[a] + mix[b];
		mix[d] = rotl(mix[d] ^ mix[a], 16);
		mix[c] = mix[c] + mix[d];
		mix[b] = rotl(mix[b] ^ mix[c], 12);
		mix[a] = mix[a] + mix[b];
		mix[d] = rotl(mix[d] ^ mix[a], 8);
		mix[c] = mix[c] + mix[d];
		mix[b] = rotl(mix[b] ^ mix[c], 7);
	endfunction

	// Encrypts a word; refills the keystream at word 0; counter steps at block or message end.
	function automatic out_item_t encrypt_word(input in_item_t item);
		out_item_t   res;
		logic [31:0] init [16];
		logic [3:0]  nb;
		logic [63:0] mask;
		if (word_pos == 3'd0) begin
			for (int i = 0; i < NUM_CELLS; i++) begin
				init[i] = SIGMA[i];
			end
			for (int i = 0; i < 4; i++) begin
				init[4 + 2 * i] = key_words[i][31:0];
				init[5 + 2 * i] = key_words[i][63:32];
			end
			init[12] = block_ctr[31:0];
			init[13] = block_ctr[63:32];
			init[14] = nonce[31:0];
			init[15] = nonce[63:32];
			mix = init;
			for (int dr = 0; dr < (ROUND_COUNT + 1) / 2; dr++) begin
				quarter_round(0, 4, 8, 12);
				quarter_round(1, 5, 9, 13);
				quarter_round(2, 6, 10, 14);
				quarter_round(3, 7, 11, 15);
				quarter_round(0, 5, 10, 15);
				quarter_round(1, 6, 11, 12);
				quarter_round(2, 7, 8, 13);
				quarter_round(3, 4, 9, 14);
			end
			for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
				keystream[i] = {mix[2 * i + 1] + init[2 * i + 1], mix[2 * i] + init[2 * i]};
			end
		end
		nb = (item.valid_bytes > 4'd8) ? 4'd8 : item.valid_bytes;
		mask = (nb == 4'd8) ? '1 : (64'd1 << (8 * nb)) - 64'd1;
		res.data_out = (item.data_in ^ keystream[word_pos]) & mask;
		res.valid_bytes_out = item.valid_bytes;
		res.last_out = item.last_of_message;
		if (word_pos == 3'd7 || item.last_of_message) begin
			block_ctr = block_ctr + 64'd1;
			word_pos = '0;
		end else begin
			word_pos = word_pos + 3'd1;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 100) begin
			$display("MISMATCH %s: got %h, expected %h", what, got, want);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_words[i] = '0;
			end
			for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
				keystream[i] = '0;
			end
			nonce = '0;
			block_ctr = '0;
			word_pos = '0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LOW, CFG_KEY_MID_LOW, CFG_KEY_MID_HIGH, CFG_KEY_HIGH: begin
						key_words[cfg_index[1:0]] = cfg_data;
						block_ctr = '0;
						word_pos = '0;
					end
					CFG_NONCE: begin
						nonce = cfg_data;
						block_ctr = '0;
						word_pos = '0;
					end
					CFG_START_COUNTER: begin
						block_ctr = cfg_data;
						word_pos = '0;
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready) begin
				expected_words.push_back(encrypt_word(in_item));
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("item with nothing expected", out_item.data_out, '0);
				end else begin
					want = expected_words.pop_front();
					if (out_item.data_out !== want.data_out) begin
						report_mismatch("data_out", out_item.data_out, want.data_out);
					end
					if (out_item.valid_bytes_out !== want.valid_bytes_out) begin
						report_mismatch("valid_bytes_out", 64'(out_item.valid_bytes_out),
							64'(want.valid_bytes_out));
					end
					if (out_item.last_out !== want.last_out) begin
						report_mismatch("last_out", 64'(out_item.last_out), 64'(want.last_out));
					end
				end
			end
		end
		fail_count <= mismatches;
		pending <= expected_words.size();
	end

endmodule

FILE: dv/tb.sv
// Testbench top for the ChaCha20 stream XOR block: stimulus, pacing and the verdict.
`timescale 1ns / 1ps
module tb;
	import cc20_pkg::*;

	localparam int ROUNDS = 20;
	localparam int SETTLE_CYCLES = ROUNDS + 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 1030;
	localparam int SEGMENTS = 9;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	in_item_t               in_item = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_item;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int                     fail_count;
	int                     pending;
	int                     send_idle_pct = 9;
	int                     recv_idle_pct = 67;
	int                     cycle_count;

	chacha20_stream_xor #(.ROUND_COUNT(ROUNDS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	chacha20_xor_checker #(.ROUND_COUNT(ROUNDS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
			@(posedge clk);
		end
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_word(input logic [63:0] data, input logic [3:0] nbytes, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{data_in: data, valid_bytes: nbytes, last_of_message: last};
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [63:0] k [4];
		logic [63:0] nonce_val;
		logic [63:0] ctr;
		logic        early;
		logic        paused;
		int          len;
		int          n;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero key, nonce and counter straight from reset, then the byte-count corners.
		for (int i = 0; i < 8; i++) begin
			send_word('0, 4'd8, 1'b0);
		end
		send_word('1, 4'd8, 1'b0);
		send_word('1, 4'd0, 1'b0);
		send_word('1, 4'd1, 1'b0);
		send_word('1, 4'd7, 1'b0);
		send_word('1, 4'd9, 1'b0);
		send_word('1, 4'd15, 1'b1);
		send_word(rand64(), 4'd3, 1'b1);
		send_word(rand64(), 4'd8, 1'b0);
		send_word(rand64(), 4'd8, 1'b0);
		drain();

		// A key write part-way through a block must start a fresh block at counter zero.
		write_reg(CFG_KEY_HIGH, '1);
		end_writes();
		send_word(rand64(), 4'd8, 1'b0);
		drain();

		// Counter carry from word 12 into word 13; writes beyond the register list are ignored.
		write_reg(CFG_START_COUNTER, 64'h0000_0000_ffff_ffff);
		write_reg(CFG_START_COUNTER + 3'd1, rand64());
		write_reg(CFG_START_COUNTER + 3'd2, rand64());
		end_writes();
		send_word(rand64(), 4'd8, 1'b1);
		send_word(rand64(), 4'd8, 1'b0);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			if (seg < 3) begin
				send_idle_pct = 9;
				recv_idle_pct <= 67;
			end else if (seg < 6) begin
				send_idle_pct = 67;
				recv_idle_pct <= 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end

			for (int i = 0; i < 4; i++) begin
				k[i] = (seg == 0) ? '1 : (seg == 1) ? '0 : rand64();
			end
			nonce_val = (seg == 0) ? '1 : (seg == 1) ? '0 : rand64();
			if (seg == 0) begin
				ctr = '1;
			end else if (seg == 1) begin
				ctr = 64'h0000_0000_ffff_fffe;
			end else if ($urandom_range(1)) begin
				ctr = rand64();
			end else begin
				ctr = {$urandom, 32'hffff_fff0};
			end
			early = (seg >= 2) && $urandom_range(1);
			if (early) begin
				write_reg(CFG_START_COUNTER, ctr);
			end
			write_reg(CFG_KEY_LOW, k[0]);
			write_reg(CFG_KEY_MID_LOW, k[1]);
			write_reg(CFG_KEY_MID_HIGH, k[2]);
			write_reg(CFG_KEY_HIGH, k[3]);
			write_reg(CFG_NONCE, nonce_val);
			if (!early) begin
				write_reg(CFG_START_COUNTER, ctr);
			end
			end_writes();

			n = 0;
			paused = 1'b0;
			while (n < RANDOM_WORDS / SEGMENTS) begin
				if (!paused && n >= RANDOM_WORDS / (2 * SEGMENTS)) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(99) < 85) begin
					len = ($urandom_range(3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
					for (int i = 0; i < len; i++) begin
						send_word(rand64(),
							4'((i == len - 1) ? $urandom_range(1, 8) : 8),
							i == len - 1);
					end
					n += len;
				end else begin
					send_word(rand64(), 4'($urandom_range(15)), 1'($urandom_range(1)));
					n++;
				end
			end
		end

		drain();
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
